/* rtl/led_driver_gray_serializer_top_macros.svh */
// ----------------------------------------------------------------------------
// LED driver grayscale serializer: assertion macros
// Shared concurrent assertion wrappers for the serializer checker.
// ----------------------------------------------------------------------------
`ifndef LED_DRIVER_GRAY_SERIALIZER_TOP_MACROS_SVH
`define LED_DRIVER_GRAY_SERIALIZER_TOP_MACROS_SVH

// Clocked assertion, muted while reset is held
`define LEDGS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked assertion that also checks across reset
`define LEDGS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ledgs_pkg.sv */
// ----------------------------------------------------------------------------
// LED driver grayscale serializer package
// Shared widths, codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package ledgs_pkg;

    // Fixed field widths
    localparam int WordW   = 16;
    localparam int BeatW   = 5;
    localparam int NumLanes = 6;

    typedef logic [BeatW-1:0] t_beat_cnt;

    // Request kinds
    localparam logic KindGray = 1'b0;
    localparam logic KindCmd  = 1'b1;

    // Largest latch-enable tail
    localparam t_beat_cnt MaxTail = 5'd16;

    // Per-beat control from the sequencer to the merge stage
    typedef struct packed {
        logic push;
        logic le;
        logic last;
    } t_beat_ctl;

endpackage

`default_nettype wire

/* rtl/ledgs_in_if.sv */
// ----------------------------------------------------------------------------
// LED driver grayscale serializer: input channel
// Valid/ready channel carrying one grayscale or latch-enable request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ledgs_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [ledgs_pkg::WordW-1:0]    top_red;
    logic [ledgs_pkg::WordW-1:0]    top_green;
    logic [ledgs_pkg::WordW-1:0]    top_blue;
    logic [ledgs_pkg::WordW-1:0]    bottom_red;
    logic [ledgs_pkg::WordW-1:0]    bottom_green;
    logic [ledgs_pkg::WordW-1:0]    bottom_blue;
    logic [ledgs_pkg::BeatW-1:0]    le_clocks;

    modport source (
        output valid, kind, top_red, top_green, top_blue,
               bottom_red, bottom_green, bottom_blue, le_clocks,
        input  ready
    );

    modport sink (
        input  valid, kind, top_red, top_green, top_blue,
               bottom_red, bottom_green, bottom_blue, le_clocks,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/ledgs_out_if.sv */
// ----------------------------------------------------------------------------
// LED driver grayscale serializer: output channel
// Valid/ready channel carrying one clock beat of the driver bus.
// ----------------------------------------------------------------------------
`default_nettype none

interface ledgs_out_if;
    logic                              valid;
    logic                              ready;
    logic [ledgs_pkg::NumLanes-1:0]    color_bits;
    logic                              latch_enable;
    logic                              last;

    modport source (
        output valid, color_bits, latch_enable, last,
        input  ready
    );

    modport sink (
        input  valid, color_bits, latch_enable, last,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/ledgs_lane.sv */
// ----------------------------------------------------------------------------
// LED driver grayscale serializer: channel lane
// One color channel shift register, MSB first, one bit per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ledgs_lane #(
    parameter int GRAY_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_load,
    input  wire logic                 i_shift,
    input  wire logic [GRAY_BITS-1:0] i_data,
    output logic                      o_bit
);

    logic [GRAY_BITS-1:0] r_shift;
    logic [GRAY_BITS-1:0] n_shift;

    // Load wins over shift: a new request may arrive with the last beat
    always_comb begin
        n_shift = r_shift;
        if (i_load) begin
            n_shift = i_data;
        end else if (i_shift) begin
            n_shift = {r_shift[GRAY_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    assign o_bit = r_shift[GRAY_BITS-1];

endmodule

`default_nettype wire

/* rtl/ledgs_merge.sv */
// ----------------------------------------------------------------------------
// LED driver grayscale serializer: merge stage
// Gathers the lane bits and beat flags into the registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ledgs_merge (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ledgs_pkg::t_beat_ctl           i_ctl,
    input  wire logic [ledgs_pkg::NumLanes-1:0] i_lane_bits,
    output logic                                o_take,
    ledgs_out_if.source                         o_beat
);

    logic                           r_valid;
    logic                           n_valid;
    logic [ledgs_pkg::NumLanes-1:0] r_color;
    logic                           r_le;
    logic                           r_last;

    // Output register frees up when empty or being drained
    assign o_take = !r_valid || o_beat.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = i_ctl.push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Beat payload, lane i drives color bit i
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && o_take) begin
            r_color <= i_lane_bits;
            r_le    <= i_ctl.le;
            r_last  <= i_ctl.last;
        end
    end

    assign o_beat.valid        = r_valid;
    assign o_beat.color_bits   = r_color;
    assign o_beat.latch_enable = r_le;
    assign o_beat.last         = r_last;

endmodule

`default_nettype wire

/* rtl/led_driver_gray_serializer_top.sv */
// First beat: an accepted request loads the sequencer and lanes, and its first
//   beat is registered in the merge stage once the output register is free.
// Beats: a grayscale request gives GRAY_BITS beats, a command gives its
//   latch-enable count (saturated at 16) in beats, an empty command none;
//   the beat counter emits one beat per cycle unless stalled, and the next
//   request loads with the final beat. Output stalls hold the beat counter.
// Reset: synchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// LED driver grayscale serializer top level
// Six channel lanes shift out in parallel under one beat sequencer; the
// merge stage registers each beat with its latch-enable and last flags.
// ----------------------------------------------------------------------------
`default_nettype none

module led_driver_gray_serializer_top #(
    parameter int GRAY_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ledgs_in_if.sink     i_gs,
    ledgs_out_if.source  o_beat
);

    localparam ledgs_pkg::t_beat_cnt GrayBeats = ledgs_pkg::t_beat_cnt'(GRAY_BITS);

    logic                  r_busy;
    logic                  n_busy;
    logic                  r_cmd;
    logic                  n_cmd;
    ledgs_pkg::t_beat_cnt  r_beats_left;
    ledgs_pkg::t_beat_cnt  n_beats_left;
    ledgs_pkg::t_beat_cnt  r_tail;
    ledgs_pkg::t_beat_cnt  n_tail;

    logic                  w_accept;
    logic                  w_start;
    logic                  w_take;
    logic                  w_advance;
    logic                  w_last_beat;
    logic                  w_is_cmd;
    ledgs_pkg::t_beat_cnt  w_le_sat;
    ledgs_pkg::t_beat_cnt  w_bit;
    ledgs_pkg::t_beat_ctl  w_ctl;

    logic [GRAY_BITS-1:0]             w_lane_in [ledgs_pkg::NumLanes];
    logic [ledgs_pkg::NumLanes-1:0]   w_lane_bits;

    // Request handshake: next request loads alongside the final beat
    assign w_advance   = r_busy && w_take;
    assign w_last_beat = (r_beats_left == ledgs_pkg::t_beat_cnt'(1));
    assign i_gs.ready  = !r_busy || (w_advance && w_last_beat);
    assign w_accept    = i_gs.valid && i_gs.ready;
    assign w_is_cmd    = (i_gs.kind == ledgs_pkg::KindCmd);

    // Saturate latch-enable count
    assign w_le_sat = (i_gs.le_clocks > ledgs_pkg::MaxTail) ? ledgs_pkg::MaxTail
                                                            : i_gs.le_clocks;

    // An empty command produces no beats
    assign w_start = w_accept && (!w_is_cmd || (w_le_sat != '0));

    // Beat sequencer
    always_comb begin
        n_busy       = r_busy;
        n_cmd        = r_cmd;
        n_beats_left = r_beats_left;
        n_tail       = r_tail;
        if (w_advance) begin
            n_beats_left = r_beats_left - ledgs_pkg::t_beat_cnt'(1);
            if (w_last_beat) begin
                n_busy = 1'b0;
            end
        end
        if (w_start) begin
            n_busy       = 1'b1;
            n_cmd        = w_is_cmd;
            n_tail       = w_le_sat;
            n_beats_left = w_is_cmd ? w_le_sat : GrayBeats;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_cmd        <= 1'b0;
            r_beats_left <= '0;
            r_tail       <= '0;
        end else begin
            r_busy       <= n_busy;
            r_cmd        <= n_cmd;
            r_beats_left <= n_beats_left;
            r_tail       <= n_tail;
        end
    end

    // Bit position being sent and beat flags
    assign w_bit      = r_beats_left - ledgs_pkg::t_beat_cnt'(1);
    assign w_ctl.push = w_advance;
    assign w_ctl.le   = r_cmd || (w_bit < r_tail);
    assign w_ctl.last = w_last_beat;

    // Lane data: commands shift out zeros
    assign w_lane_in[0] = w_is_cmd ? '0 : i_gs.top_red[GRAY_BITS-1:0];
    assign w_lane_in[1] = w_is_cmd ? '0 : i_gs.top_green[GRAY_BITS-1:0];
    assign w_lane_in[2] = w_is_cmd ? '0 : i_gs.top_blue[GRAY_BITS-1:0];
    assign w_lane_in[3] = w_is_cmd ? '0 : i_gs.bottom_red[GRAY_BITS-1:0];
    assign w_lane_in[4] = w_is_cmd ? '0 : i_gs.bottom_green[GRAY_BITS-1:0];
    assign w_lane_in[5] = w_is_cmd ? '0 : i_gs.bottom_blue[GRAY_BITS-1:0];

    // Channel lanes
    for (genvar g = 0; g < ledgs_pkg::NumLanes; g++) begin : g_lane
        ledgs_lane #(
            .GRAY_BITS (GRAY_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_load  (w_start),
            .i_shift (w_advance),
            .i_data  (w_lane_in[g]),
            .o_bit   (w_lane_bits[g])
        );
    end

    // Merge lanes into the output beat
    ledgs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_lane_bits (w_lane_bits),
        .o_take      (w_take),
        .o_beat      (o_beat)
    );

endmodule

`default_nettype wire

/* rtl/ledgs_checker.sv */
// ----------------------------------------------------------------------------
// LED driver grayscale serializer: port checker
// Watches the top-level channels and flags ordering or handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_driver_gray_serializer_top_macros.svh"

module ledgs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_kind,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_last
);

    logic w_gray_req;

    assign w_gray_req = i_in_valid && i_in_ready && (i_in_kind == ledgs_pkg::KindGray);

    // A pending beat stays until taken
    `LEDGS_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "beat dropped while stalled")

    // A grayscale request shows a beat once past the sequencer and merge output registers
    `LEDGS_ASSERT(a_gray_first, i_clk, i_rst_n, w_gray_req |-> ##2 i_out_valid, "grayscale request gave no beat")

    // No new request while a stalled beat is mid-item
    `LEDGS_ASSERT(a_no_overlap, i_clk, i_rst_n, (i_out_valid && !i_out_ready && !i_out_last) |-> !i_in_ready, "request taken mid-item")

    // Reset empties the output
    `LEDGS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind led_driver_gray_serializer_top ledgs_checker u_ledgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_gs.valid),
    .i_in_ready  (i_gs.ready),
    .i_in_kind   (i_gs.kind),
    .i_out_valid (o_beat.valid),
    .i_out_ready (o_beat.ready),
    .i_out_last  (o_beat.last)
);

`default_nettype wire

/* dv/led_driver_gray_serializer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED driver grayscale serializer: scoreboard
// Watches the request and beat channels, expands every accepted request into
// the beats the driver bus should carry, and compares each accepted beat
// field by field against the oldest outstanding beat.
// ----------------------------------------------------------------------------

module led_driver_gray_serializer_checker #(
    parameter int GRAY_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ledgs_in_if       i_gs,
    ledgs_out_if      i_beat,
    input  wire logic i_end_check,
    output int        o_fail_count,
    output int        o_pending
);
    import ledgs_pkg::*;

    typedef struct packed {
        logic [NumLanes-1:0] color;
        logic                le;
        logic                last;
    } t_bus_beat;

    t_bus_beat bus_beats_due[$];
    int        fail_count = 0;
    bit        leftover_checked = 1'b0;

    assign o_fail_count = fail_count;

    initial o_pending = 0;

    // One line per mismatch, counted for the verdict
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] led_driver_gray_serializer: %s: got %0h, expected %0h",
                 $time, what, got, want);
        fail_count++;
    endtask

    // Expand one request into the beats it drives onto the bus
    task automatic expand_request();
        t_beat_cnt           tail;
        logic [WordW-1:0]    lanes [NumLanes];
        t_bus_beat           b;
        tail = (i_gs.le_clocks > MaxTail) ? MaxTail : i_gs.le_clocks;
        if (i_gs.kind == KindCmd) begin
            // latch-enable only, no data; an empty command drives nothing
            for (int n = int'(tail); n > 0; n--) begin
                b.color = '0;
                b.le    = 1'b1;
                b.last  = (n == 1);
                bus_beats_due.push_back(b);
            end
        end else begin
            lanes[0] = i_gs.top_red;
            lanes[1] = i_gs.top_green;
            lanes[2] = i_gs.top_blue;
            lanes[3] = i_gs.bottom_red;
            lanes[4] = i_gs.bottom_green;
            lanes[5] = i_gs.bottom_blue;
            // MSB first; latch-enable on the final 'tail' beats
            for (int bit_pos = GRAY_BITS - 1; bit_pos >= 0; bit_pos--) begin
                for (int lane = 0; lane < NumLanes; lane++)
                    b.color[lane] = lanes[lane][bit_pos];
                b.le   = (bit_pos < int'(tail));
                b.last = (bit_pos == 0);
                bus_beats_due.push_back(b);
            end
        end
    endtask

    // Track requests, check beats
    always @(posedge i_clk) begin
        t_bus_beat want;
        if (i_rst_n) begin
            if (i_gs.valid && i_gs.ready)
                expand_request();
            if (i_beat.valid && i_beat.ready) begin
                if (bus_beats_due.size() == 0) begin
                    report_mismatch("beat with nothing outstanding",
                                    {i_beat.color_bits, i_beat.latch_enable, i_beat.last}, 0);
                end else begin
                    want = bus_beats_due.pop_front();
                    if (i_beat.color_bits !== want.color)
                        report_mismatch("color_bits", i_beat.color_bits, want.color);
                    if (i_beat.latch_enable !== want.le)
                        report_mismatch("latch_enable", i_beat.latch_enable, want.le);
                    if (i_beat.last !== want.last)
                        report_mismatch("last", i_beat.last, want.last);
                end
            end
        end
        // beats still owed once stimulus has drained
        if (i_end_check && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (bus_beats_due.size() != 0)
                report_mismatch("beats never delivered", bus_beats_due.size(), 0);
        end
        o_pending <= bus_beats_due.size();
    end

endmodule

/* dv/led_driver_gray_serializer_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED driver grayscale serializer testbench
// Drives directed and random grayscale and latch-enable requests through
// phases of sender gaps and beat-side backpressure; the scoreboard module
// checks every beat and this top gives the verdict.
// ----------------------------------------------------------------------------

module led_driver_gray_serializer_top_tb;
    import ledgs_pkg::*;

    localparam int GRAY_BITS    = 16;
    localparam int RANDOM_ITEMS = 160;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [NumLanes-1:0][WordW-1:0] t_lane_words;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic end_check;
    int   fail_count;
    int   beats_pending;
    int   idle_pct  = 0;
    int   stall_pct = 0;

    ledgs_in_if  gs_if ();
    ledgs_out_if beat_if ();

    led_driver_gray_serializer_top #(
        .GRAY_BITS (GRAY_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gs    (gs_if),
        .o_beat  (beat_if)
    );

    led_driver_gray_serializer_checker #(
        .GRAY_BITS (GRAY_BITS)
    ) scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gs         (gs_if),
        .i_beat       (beat_if),
        .i_end_check  (end_check),
        .o_fail_count (fail_count),
        .o_pending    (beats_pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Beat-side backpressure
    always @(posedge i_clk) begin
        beat_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop
    initial begin
        #1000000;
        $display("led_driver_gray_serializer_top_tb: done, errors");
        $finish;
    end

    // Present one request, with random gaps ahead of it, until accepted
    task automatic send_request(input logic kind, input t_lane_words lanes,
                                input logic [BeatW-1:0] le_clocks);
        while ($urandom_range(99) < idle_pct) begin
            gs_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        gs_if.valid        <= 1'b1;
        gs_if.kind         <= kind;
        gs_if.top_red      <= lanes[0];
        gs_if.top_green    <= lanes[1];
        gs_if.top_blue     <= lanes[2];
        gs_if.bottom_red   <= lanes[3];
        gs_if.bottom_green <= lanes[4];
        gs_if.bottom_blue  <= lanes[5];
        gs_if.le_clocks    <= le_clocks;
        @(posedge i_clk);
        while (!gs_if.ready) @(posedge i_clk);
    endtask

    // Hold off until every outstanding beat has arrived
    task automatic wait_drained();
        gs_if.valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (beats_pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [WordW-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return WordW'($urandom);
        endcase
    endfunction

    function automatic t_lane_words rand_lanes();
        t_lane_words w;
        for (int lane = 0; lane < NumLanes; lane++)
            w[lane] = rand_word();
        return w;
    endfunction

    // Stimulus
    initial begin
        t_lane_words w;
        logic        kind;
        logic [BeatW-1:0] le;

        i_rst_n            = 1'b0;
        end_check          = 1'b0;
        gs_if.valid        = 1'b0;
        gs_if.kind         = KindGray;
        gs_if.top_red      = '0;
        gs_if.top_green    = '0;
        gs_if.top_blue     = '0;
        gs_if.bottom_red   = '0;
        gs_if.bottom_green = '0;
        gs_if.bottom_blue  = '0;
        gs_if.le_clocks    = '0;
        beat_if.ready      = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: data extremes, tail lengths, saturation, commands
        send_request(KindGray, '0, 5'd0);
        send_request(KindGray, '1, 5'd16);
        send_request(KindGray, '1, 5'd31);
        send_request(KindGray, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
                     5'd15);
        send_request(KindGray, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
                     5'd1);
        send_request(KindGray, rand_lanes(), 5'd17);
        // each lane alone, MSB and LSB set
        for (int lane = 0; lane < NumLanes; lane++) begin
            w       = '0;
            w[lane] = 16'h8001;
            send_request(KindGray, w, BeatW'(lane + 2));
        end
        send_request(KindCmd, '0, 5'd0);
        send_request(KindCmd, '0, 5'd1);
        send_request(KindCmd, '1, 5'd16);
        send_request(KindCmd, rand_lanes(), 5'd31);
        send_request(KindCmd, '1, 5'd0);
        send_request(KindGray, rand_lanes(), 5'd0);
        send_request(KindCmd, rand_lanes(), 5'd8);

        // sender holds off until the bus has gone quiet
        wait_drained();
        repeat (4) @(posedge i_clk);

        // Random phases: free-running, sender gaps, backpressure, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                kind = ($urandom_range(9) < 3) ? KindCmd : KindGray;
                le   = ($urandom_range(9) == 0) ? BeatW'($urandom_range(31, 17))
                                                : BeatW'($urandom_range(16));
                send_request(kind, rand_lanes(), le);
            end
        end

        // Drain, then allow for trailing empty commands
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("led_driver_gray_serializer_top_tb: done, clean");
        end else begin
            $display("led_driver_gray_serializer_top_tb: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ledgs_pkg.sv
rtl/ledgs_in_if.sv
rtl/ledgs_out_if.sv
rtl/ledgs_lane.sv
rtl/ledgs_merge.sv
rtl/led_driver_gray_serializer_top.sv
rtl/ledgs_checker.sv
dv/led_driver_gray_serializer_checker.sv
dv/led_driver_gray_serializer_top_tb.sv
